@@ src/tsce_pkg.sv @@
// Shared types, codes and helper functions for the triangle strip control encoder.
package tsce_pkg;

    localparam int VTX_W    = 8;
    localparam int ROT_W    = 2;
    localparam int PRIM_W   = 8;
    localparam int OFS_W    = 8;
    localparam int CNT_W    = 2;
    localparam int HIST_W   = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;
    localparam int S_USER_W = 1;
    localparam int M_USER_W = 2;

    // Control codes
    typedef enum logic [1:0] {
        CODE_RESTART   = 2'd0,
        CODE_EDGE1     = 2'd1,
        CODE_EDGE2     = 2'd2,
        CODE_BACKTRACK = 2'd3
    } code_t;

    localparam logic [CNT_W-1:0]  CNT_RESTART = 2'd3;
    localparam logic [CNT_W-1:0]  CNT_STRIP   = 2'd1;
    localparam logic [OFS_W-1:0]  OFS_MAX     = 8'd255;
    localparam logic [HIST_W-1:0] HIST_FULL   = 2'd2;

    typedef logic [VTX_W-1:0] vtx_t;

    // Rotated triangle, slot 0..2
    typedef struct packed {
        vtx_t s2;
        vtx_t s1;
        vtx_t s0;
    } tri_t;

    typedef struct packed {
        logic              block_start;
        vtx_t              vtx_a;
        vtx_t              vtx_b;
        vtx_t              vtx_c;
        logic [ROT_W-1:0]  rotation;
        logic [PRIM_W-1:0] prim_id;
    } item_t;

    typedef struct packed {
        code_t             control;
        logic [CNT_W-1:0]  index_count;
        vtx_t              out_idx_first;
        vtx_t              out_idx_second;
        vtx_t              out_idx_third;
        logic [OFS_W-1:0]  index_offset;
        logic [PRIM_W-1:0] remap_prim;
        logic [ROT_W-1:0]  remap_rot0;
        logic [ROT_W-1:0]  remap_rot1;
        logic [ROT_W-1:0]  remap_rot2;
    } result_t;

    // Strip history carried between triangles
    typedef struct packed {
        tri_t              prev_tri;
        tri_t              prev_prev_tri;
        code_t             prev_code;
        logic [HIST_W-1:0] history_count;
        logic [OFS_W-1:0]  index_total;
    } history_t;

    // Empty history: no triangles, previous code restart, index total zero
    localparam history_t HIST_CLEAR = '{
        prev_tri:      '0,
        prev_prev_tri: '0,
        prev_code:     CODE_RESTART,
        history_count: '0,
        index_total:   '0
    };

    // Rotation taken mod 3 (a value of 3 acts as 0)
    function automatic logic [ROT_W-1:0] rot_mod3(input logic [ROT_W-1:0] r);
        logic [ROT_W-1:0] res;
        case (r)
            2'd0:    res = 2'd0;
            2'd1:    res = 2'd1;
            2'd2:    res = 2'd2;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    // (r + 1) mod 3 for an effective rotation
    function automatic logic [ROT_W-1:0] rot_next(input logic [ROT_W-1:0] r);
        logic [ROT_W-1:0] res;
        case (r)
            2'd0:    res = 2'd1;
            2'd1:    res = 2'd2;
            2'd2:    res = 2'd0;
            default: res = 2'd1;
        endcase
        return res;
    endfunction

endpackage

@@ src/triangle_strip_control_encoder.sv @@
// Top level: input register, encoder, history and output register.
// A triangle accepted into the input register is encoded and captured in the
// result register, from which it is presented on the master side.
// Throughput: one triangle per cycle while the master side is not stalled; the
// combinational encoder and history update between the input and result registers set that figure.
// Reset (rst_n low, asynchronous): both stages empty, history cleared,
// index total zero, previous code restart.
module triangle_strip_control_encoder
    import tsce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // vtx_a[7:0], vtx_b[15:8], vtx_c[23:16], rotation[25:24], prim_id[33:26], zero pad
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // block_start[0]
    input  logic [S_USER_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // index_count[1:0], out_idx_first[9:2], out_idx_second[17:10],
    // out_idx_third[25:18], index_offset[33:26], remap_prim[41:34],
    // remap_rot0[43:42], remap_rot1[45:44], remap_rot2[47:46]
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // control[1:0]
    output logic [M_USER_W-1:0] m_axis_tuser
);

    item_t    in_item;
    item_t    item_reg;
    logic     item_valid_reg;
    history_t hist_reg;
    history_t hist_next;
    result_t  res_next;
    result_t  res_reg;
    logic     res_valid_reg;
    logic     out_free;
    logic     fire;

    // Unpack the slave transaction
    always_comb
    begin
        in_item.block_start = s_axis_tuser[0];
        in_item.vtx_a       = s_axis_tdata[7:0];
        in_item.vtx_b       = s_axis_tdata[15:8];
        in_item.vtx_c       = s_axis_tdata[23:16];
        in_item.rotation    = s_axis_tdata[25:24];
        in_item.prim_id     = s_axis_tdata[33:26];
    end

    // Stage handshake
    assign out_free      = !res_valid_reg || m_axis_tready;
    assign fire          = item_valid_reg && out_free;
    assign s_axis_tready = !item_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= in_item;
        end
    end

    tsce_encode u_encode (
        .item      (item_reg),
        .hist      (hist_reg),
        .result    (res_next),
        .hist_next (hist_next)
    );

    // Strip history, advanced once per encoded triangle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= HIST_CLEAR;
        end
        else if (fire)
        begin
            hist_reg <= hist_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // Pack the master transaction
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = res_reg.control;
    assign m_axis_tdata  = {res_reg.remap_rot2, res_reg.remap_rot1, res_reg.remap_rot0,
                            res_reg.remap_prim, res_reg.index_offset,
                            res_reg.out_idx_third, res_reg.out_idx_second,
                            res_reg.out_idx_first, res_reg.index_count};

endmodule

@@ src/tsce_encode.sv @@
// Combinational encoder: rotation, strip compares, control code and history update.
module tsce_encode
    import tsce_pkg::*;
(
    input  item_t    item,
    input  history_t hist,
    output result_t  result,
    output history_t hist_next
);

    history_t          h;
    logic [ROT_W-1:0]  rot;
    tri_t              cur;
    code_t             code;
    logic              have1;
    logic              have2;
    logic [CNT_W-1:0]  count;
    logic [OFS_W:0]    total_sum;

    // A block start clears the history ahead of this triangle
    always_comb
    begin
        if (item.block_start)
        begin
            h = '0;
            h.prev_code = CODE_RESTART;
        end
        else
        begin
            h = hist;
        end
    end

    // Rotate the vertex indices: slot i takes vertex (i + rot) mod 3
    assign rot = rot_mod3(item.rotation);

    always_comb
    begin
        case (rot)
            2'd1:
            begin
                cur.s0 = item.vtx_b;
                cur.s1 = item.vtx_c;
                cur.s2 = item.vtx_a;
            end
            2'd2:
            begin
                cur.s0 = item.vtx_c;
                cur.s1 = item.vtx_a;
                cur.s2 = item.vtx_b;
            end
            default:
            begin
                cur.s0 = item.vtx_a;
                cur.s1 = item.vtx_b;
                cur.s2 = item.vtx_c;
            end
        endcase
    end

    // Control decision, in priority order
    assign have1 = (h.history_count != '0);
    assign have2 = (h.history_count == HIST_FULL);

    always_comb
    begin
        code = CODE_RESTART;
        if (have1 && h.prev_tri.s1 == cur.s1 && h.prev_tri.s2 == cur.s0)
        begin
            code = CODE_EDGE1;
        end
        else if (have1 && h.prev_tri.s2 == cur.s1 && h.prev_tri.s0 == cur.s0)
        begin
            code = CODE_EDGE2;
        end
        else if (have2)
        begin
            if (h.prev_code == CODE_EDGE1 &&
                h.prev_prev_tri.s2 == cur.s1 && h.prev_prev_tri.s0 == cur.s0)
            begin
                code = CODE_BACKTRACK;
            end
            else if (h.prev_code == CODE_EDGE2 &&
                     h.prev_prev_tri.s1 == cur.s1 && h.prev_prev_tri.s2 == cur.s0)
            begin
                code = CODE_BACKTRACK;
            end
        end
    end

    assign count = (code == CODE_RESTART) ? CNT_RESTART : CNT_STRIP;

    // Result fields
    always_comb
    begin
        result.control     = code;
        result.index_count = count;
        if (code == CODE_RESTART)
        begin
            result.out_idx_first  = cur.s0;
            result.out_idx_second = cur.s1;
            result.out_idx_third  = cur.s2;
        end
        else
        begin
            result.out_idx_first  = cur.s2;
            result.out_idx_second = '0;
            result.out_idx_third  = '0;
        end
        result.index_offset = h.index_total;
        result.remap_prim   = item.prim_id;
        result.remap_rot0   = rot;
        result.remap_rot1   = rot_next(rot);
        result.remap_rot2   = rot_next(rot_next(rot));
    end

    // History update with saturating index total
    assign total_sum = {1'b0, h.index_total} + {{(OFS_W+1-CNT_W){1'b0}}, count};

    always_comb
    begin
        hist_next.prev_prev_tri = h.prev_tri;
        hist_next.prev_tri      = cur;
        hist_next.prev_code     = code;
        hist_next.history_count = have2 ? h.history_count : h.history_count + 2'd1;
        hist_next.index_total   = total_sum[OFS_W] ? OFS_MAX : total_sum[OFS_W-1:0];
    end

endmodule

@@ tb/triangle_strip_control_encoder_tb.sv @@
// Self-checking testbench for the triangle strip control encoder: strip-aware stimulus with a predictor.
module triangle_strip_control_encoder_tb;
    import tsce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_REPORTS = 10;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [S_USER_W-1:0] s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;

    // Predictor copy of the strip history
    tri_t              strip_last;
    tri_t              strip_before;
    code_t             last_code;
    logic [HIST_W-1:0] hist_depth;
    logic [OFS_W-1:0]  ibuf_fill;

    result_t expected_strip[$];
    int      errors;
    int      cycles;
    int      idle_pct;
    int      sink_stall;

    triangle_strip_control_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver back-pressure: tready dropped at random, each time for a burst of randomly drawn length
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall--;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            m_axis_tready <= 1'b0;
            sink_stall = $urandom_range(6, 0);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Encode one triangle against the strip history and advance it
    function automatic result_t strip_encode(input item_t it);
        result_t res;
        vtx_t    v[3];
        vtx_t    r[3];
        int      rot;
        int      fill;
        code_t   code;
        if (it.block_start)
        begin
            strip_last   = '0;
            strip_before = '0;
            last_code    = CODE_RESTART;
            hist_depth   = '0;
            ibuf_fill    = '0;
        end
        rot  = (it.rotation == 2'd3) ? 0 : int'(it.rotation);
        v[0] = it.vtx_a;
        v[1] = it.vtx_b;
        v[2] = it.vtx_c;
        for (int i = 0; i < 3; i++)
            r[i] = v[(i + rot) % 3];

        code = CODE_RESTART;
        if (hist_depth >= 1 && strip_last.s1 == r[1] && strip_last.s2 == r[0])
            code = CODE_EDGE1;
        else if (hist_depth >= 1 && strip_last.s2 == r[1] && strip_last.s0 == r[0])
            code = CODE_EDGE2;
        else if (hist_depth == 2)
        begin
            if (last_code == CODE_EDGE1 && strip_before.s2 == r[1] && strip_before.s0 == r[0])
                code = CODE_BACKTRACK;
            else if (last_code == CODE_EDGE2 && strip_before.s1 == r[1]
                     && strip_before.s2 == r[0])
                code = CODE_BACKTRACK;
        end

        res.control     = code;
        res.index_count = (code == CODE_RESTART) ? 2'd3 : 2'd1;
        if (code == CODE_RESTART)
        begin
            res.out_idx_first  = r[0];
            res.out_idx_second = r[1];
            res.out_idx_third  = r[2];
        end
        else
        begin
            res.out_idx_first  = r[2];
            res.out_idx_second = '0;
            res.out_idx_third  = '0;
        end
        res.index_offset = ibuf_fill;
        res.remap_prim   = it.prim_id;
        res.remap_rot0   = rot[ROT_W-1:0];
        res.remap_rot1   = ROT_W'((rot + 1) % 3);
        res.remap_rot2   = ROT_W'((rot + 2) % 3);

        // Saturating index buffer fill and history shift
        fill         = int'(ibuf_fill) + int'(res.index_count);
        ibuf_fill    = (fill > 255) ? 8'd255 : fill[OFS_W-1:0];
        strip_before = strip_last;
        strip_last   = {r[2], r[1], r[0]};
        last_code    = code;
        if (hist_depth < 2)
            hist_depth = hist_depth + 1'b1;
        return res;
    endfunction

    function automatic item_t mk_item(input logic bs, input int a, input int b, input int c,
                                      input int rot, input int prim);
        item_t it;
        it.block_start = bs;
        it.vtx_a       = a[VTX_W-1:0];
        it.vtx_b       = b[VTX_W-1:0];
        it.vtx_c       = c[VTX_W-1:0];
        it.rotation    = rot[ROT_W-1:0];
        it.prim_id     = prim[PRIM_W-1:0];
        return it;
    endfunction

    // Build a triangle that continues the current strip with the wanted code
    function automatic item_t follow_item(input code_t want);
        item_t it;
        vtx_t  r[3];
        vtx_t  v[3];
        int    rot;
        for (int i = 0; i < 3; i++)
            r[i] = VTX_W'($urandom_range(255));
        case (want)
            CODE_EDGE1:
                if (hist_depth >= 1)
                begin
                    r[0] = strip_last.s2;
                    r[1] = strip_last.s1;
                end
            CODE_EDGE2:
                if (hist_depth >= 1)
                begin
                    r[0] = strip_last.s0;
                    r[1] = strip_last.s2;
                end
            CODE_BACKTRACK:
                if (hist_depth == 2 && last_code == CODE_EDGE1)
                begin
                    r[0] = strip_before.s0;
                    r[1] = strip_before.s2;
                end
                else if (hist_depth == 2 && last_code == CODE_EDGE2)
                begin
                    r[0] = strip_before.s2;
                    r[1] = strip_before.s1;
                end
            default:
                ;
        endcase
        it.block_start = 1'b0;
        it.prim_id     = PRIM_W'($urandom_range(255));
        it.rotation    = ROT_W'($urandom_range(3));
        rot            = (it.rotation == 2'd3) ? 0 : int'(it.rotation);
        for (int i = 0; i < 3; i++)
            v[(i + rot) % 3] = r[i];
        it.vtx_a = v[0];
        it.vtx_b = v[1];
        it.vtx_c = v[2];
        return it;
    endfunction

    // Vertices from a tiny pool, so matches and ties turn up by chance
    function automatic item_t noise_item();
        return mk_item($urandom_range(7) == 0, $urandom_range(3), $urandom_range(3),
                       $urandom_range(3), $urandom_range(3), $urandom_range(255));
    endfunction

    // Send one triangle; the expectation is queued on acceptance
    task automatic send_tri(input item_t it);
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.prim_id, it.rotation, it.vtx_c, it.vtx_b, it.vtx_a};
        s_axis_tuser  <= it.block_start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_strip.push_back(strip_encode(it));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_strip.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d", $realtime, name, exp_v, act_v);
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin : result_check
        result_t act;
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act.control        = code_t'(m_axis_tuser);
            act.index_count    = m_axis_tdata[1:0];
            act.out_idx_first  = m_axis_tdata[9:2];
            act.out_idx_second = m_axis_tdata[17:10];
            act.out_idx_third  = m_axis_tdata[25:18];
            act.index_offset   = m_axis_tdata[33:26];
            act.remap_prim     = m_axis_tdata[41:34];
            act.remap_rot0     = m_axis_tdata[43:42];
            act.remap_rot1     = m_axis_tdata[45:44];
            act.remap_rot2     = m_axis_tdata[47:46];
            if (expected_strip.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected", $realtime);
            end
            else
            begin
                exp_r = expected_strip.pop_front();
                check_field("control", int'(exp_r.control), int'(act.control));
                check_field("index_count", int'(exp_r.index_count), int'(act.index_count));
                check_field("out_idx_first", int'(exp_r.out_idx_first),
                            int'(act.out_idx_first));
                check_field("out_idx_second", int'(exp_r.out_idx_second),
                            int'(act.out_idx_second));
                check_field("out_idx_third", int'(exp_r.out_idx_third),
                            int'(act.out_idx_third));
                check_field("index_offset", int'(exp_r.index_offset), int'(act.index_offset));
                check_field("remap_prim", int'(exp_r.remap_prim), int'(act.remap_prim));
                check_field("remap_rot0", int'(exp_r.remap_rot0), int'(act.remap_rot0));
                check_field("remap_rot1", int'(exp_r.remap_rot1), int'(act.remap_rot1));
                check_field("remap_rot2", int'(exp_r.remap_rot2), int'(act.remap_rot2));
            end
        end
    end

    // First triangles without a block start: empty history, so a restart, then an edge
    task automatic test_no_start_after_reset();
        send_tri(mk_item(1'b0, 0, 0, 0, 0, 0));
        send_tri(mk_item(1'b0, 0, 0, 0, 0, 1));
    endtask

    task automatic test_field_extremes();
        send_tri(mk_item(1'b1, 255, 255, 255, 2, 255));
        send_tri(mk_item(1'b0, 255, 0, 255, 1, 0));
        send_tri(mk_item(1'b1, 8'hAA, 8'h55, 8'hAA, 0, 8'h55));
        send_tri(mk_item(1'b0, 8'h55, 8'hAA, 8'h55, 2, 8'hAA));
    endtask

    // A rotation of three acts as zero
    task automatic test_rotation_three();
        send_tri(mk_item(1'b1, 1, 2, 3, 3, 8'hAA));
        send_tri(mk_item(1'b0, 3, 2, 7, 3, 8'h55));
        send_tri(mk_item(1'b0, 9, 8, 7, 3, 8'h0F));
    endtask

    task automatic test_control_codes();
        send_tri(mk_item(1'b1, 10, 20, 30, 0, 4));
        send_tri(follow_item(CODE_EDGE1));
        send_tri(follow_item(CODE_BACKTRACK));
        send_tri(mk_item(1'b1, 40, 50, 60, 1, 5));
        send_tri(follow_item(CODE_EDGE2));
        send_tri(follow_item(CODE_BACKTRACK));
        send_tri(follow_item(CODE_EDGE1));
        send_tri(follow_item(CODE_EDGE2));
        send_tri(follow_item(CODE_RESTART));
        // Backtrack asked with only one history triangle falls back to restart
        send_tri(mk_item(1'b1, 70, 80, 90, 2, 6));
        send_tri(follow_item(CODE_BACKTRACK));
    endtask

    // Mostly well-formed strips, with broken sequences and noise mixed in
    task automatic test_random_strips(input int n_items, input bit quiet);
        int    sent;
        int    len;
        int    pick;
        item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            idle_pct = (quiet || $urandom_range(3) == 0) ? 0 : 30;
            len      = $urandom_range(12, 1);
            for (int k = 0; k < len && sent < n_items; k++)
            begin
                pick = $urandom_range(99);
                if (k == 0)
                begin
                    it             = follow_item(CODE_RESTART);
                    it.block_start = ($urandom_range(3) != 0);
                end
                else if (pick < 38)
                    it = follow_item(CODE_EDGE1);
                else if (pick < 66)
                    it = follow_item(CODE_EDGE2);
                else if (pick < 84)
                    it = follow_item(CODE_BACKTRACK);
                else if (pick < 92)
                    it = noise_item();
                else
                begin
                    it             = follow_item(CODE_RESTART);
                    it.block_start = 1'($urandom_range(1));
                end
                send_tri(it);
                sent++;
            end
        end
    endtask

    // Block far longer than intended: the index offset saturates and stays there
    task automatic test_offset_saturation();
        item_t it;
        idle_pct       = 20;
        it             = follow_item(CODE_RESTART);
        it.block_start = 1'b1;
        send_tri(it);
        repeat (90) send_tri(follow_item(CODE_RESTART));
        repeat (3) send_tri(follow_item(CODE_EDGE1));
        send_tri(follow_item(CODE_BACKTRACK));
        send_tri(follow_item(CODE_EDGE2));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        errors        = 0;
        cycles        = 0;
        sink_stall    = 0;
        idle_pct      = 30;
        strip_last    = '0;
        strip_before  = '0;
        last_code     = CODE_RESTART;
        hist_depth    = '0;
        ibuf_fill     = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_start_after_reset();
        test_field_extremes();
        test_rotation_three();
        test_control_codes();
        test_random_strips(350, 1'b0);
        wait_for_results();
        test_offset_saturation();
        test_random_strips(300, 1'b0);
        test_random_strips(150, 1'b1);

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && expected_strip.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
